[design/ntoe_pkg.sv]
// Package for the neighbor table: sizes, codes, register reset values and
// the word types that pass between the front end, command queue and back end.
// No dependencies.
package ntoe_pkg;

  // Table geometry
  localparam int TABLE_SLOTS = 16;
  localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);
  localparam int COUNT_OUT_W = 5;

  // Command queue between front and back end
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [31:0] MAX_AGE_RESET    = 32'd60;
  localparam logic [7:0]  DIRECT_TTL_RESET = 8'd3;

  // Result status codes
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_MISS = 1'b1;

  typedef enum logic [1:0] {
    OP_UPDATE = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_AGE    = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic {
    REG_MAX_AGE    = 1'b0,
    REG_DIRECT_TTL = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } back_state_t;

  // Input word as it arrives
  typedef struct packed {
    logic [1:0]         command;
    logic [15:0]        node_id;
    logic signed [15:0] rssi;
    logic signed [7:0]  snr;
    logic [7:0]         ttl;
    logic [31:0]        now_seconds;
  } in_item_t;

  // Result word
  typedef struct packed {
    logic                   status;
    logic [15:0]            found_node_id;
    logic signed [15:0]     found_rssi;
    logic signed [7:0]      found_snr;
    logic                   found_direct;
    logic [31:0]            found_last_seen;
    logic                   evicted;
    logic [COUNT_OUT_W-1:0] removed_count;
    logic [COUNT_OUT_W-1:0] occupied_count;
  } out_item_t;

  // Classified command word held in the queue
  typedef struct packed {
    op_t                op;
    logic [15:0]        node;
    logic signed [15:0] rssi;
    logic signed [7:0]  snr;
    logic               heard_direct;
    logic [31:0]        now;
  } cmd_t;

  // Configuration register values
  typedef struct packed {
    logic [31:0] max_age;
    logic [7:0]  direct_ttl;
  } cfg_t;

endpackage

[design/ntoe_cfg.sv]
// APB-style configuration registers: max age and direct ttl.
// Depends on ntoe_pkg.
module ntoe_cfg import ntoe_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic [31:0] max_age_r;
  logic [7:0]  direct_ttl_r;
  reg_idx_t    reg_sel;
  logic        wr_en;

  // Decode the word address
  assign reg_sel = reg_idx_t'(paddr[2]);
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  // Write registers on the access cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_age_r    <= MAX_AGE_RESET;
      direct_ttl_r <= DIRECT_TTL_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_MAX_AGE:    max_age_r    <= pwdata;
        REG_DIRECT_TTL: direct_ttl_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Return the addressed register
  always_comb begin
    unique case (reg_sel)
      REG_MAX_AGE:    prdata = max_age_r;
      REG_DIRECT_TTL: prdata = {{(CFG_DATA_W-8){1'b0}}, direct_ttl_r};
      default:        prdata = '0;
    endcase
  end

  assign cfg.max_age    = max_age_r;
  assign cfg.direct_ttl = direct_ttl_r;

endmodule

[design/ntoe_front.sv]
// Front end: accepts input words, classifies the command and the direct flag,
// and hands classified commands to the command queue. Depends on ntoe_pkg.
module ntoe_front import ntoe_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  output logic     full,
  input  in_item_t in_data,
  input  cfg_t     cfg,
  output logic     q_push,
  output cmd_t     q_data,
  input  logic     q_full
);

  logic valid_r;
  logic valid_nxt;
  cmd_t item_r;
  cmd_t item_nxt;
  logic accept;

  // Hold the staged word until the queue takes it
  assign full      = valid_r & q_full;
  assign accept    = push & ~full;
  assign q_push    = valid_r & ~q_full;
  assign q_data    = item_r;
  assign valid_nxt = accept | (valid_r & q_full);

  // Classify the incoming word
  always_comb begin
    item_nxt.op           = op_t'(in_data.command);
    item_nxt.node         = in_data.node_id;
    item_nxt.rssi         = in_data.rssi;
    item_nxt.snr          = in_data.snr;
    item_nxt.heard_direct = (in_data.ttl == cfg.direct_ttl);
    item_nxt.now          = in_data.now_seconds;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_nxt;
    end
  end

endmodule

[design/ntoe_cmdq.sv]
// Short command queue that decouples the front end from the table back end.
// Depends on ntoe_pkg.
module ntoe_cmdq import ntoe_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t wr_data,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t rd_data
);

  cmd_t                  entry_r [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr_r;
  logic [CMDQ_PTR_W-1:0] rd_ptr_r;
  logic [CMDQ_CNT_W-1:0] cnt_r;
  logic                  do_push;
  logic                  do_pop;

  assign full    = (cnt_r == CMDQ_CNT_W'(CMDQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rd_data = entry_r[rd_ptr_r];

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // Store pushed words
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

[design/ntoe_back.sv]
// Back end: holds the neighbor table, scans it one slot per cycle for each
// command but a clear, commits the change and holds the result word. Depends on ntoe_pkg.
module ntoe_back import ntoe_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      q_empty,
  input  cmd_t      q_data,
  output logic      q_pop,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_data
);

  // Table storage
  logic [TABLE_SLOTS-1:0] occ_r;
  logic [TABLE_SLOTS-1:0] occ_nxt;
  logic [15:0]            node_r   [TABLE_SLOTS];
  logic signed [15:0]     rssi_r   [TABLE_SLOTS];
  logic signed [7:0]      snr_r    [TABLE_SLOTS];
  logic                   direct_r [TABLE_SLOTS];
  logic [31:0]            seen_r   [TABLE_SLOTS];
  logic [CNT_W-1:0]       occ_cnt_r;
  logic [CNT_W-1:0]       occ_cnt_nxt;

  // Sequencer
  back_state_t state_r;
  back_state_t state_nxt;
  logic        start;
  logic        scan_en;
  logic        commit;

  // Per-command tracking
  cmd_t               cmd_r;
  logic [SLOT_W-1:0]  idx_r;
  logic               hit_r;
  logic [SLOT_W-1:0]  hit_idx_r;
  logic               free_r;
  logic [SLOT_W-1:0]  free_idx_r;
  logic [SLOT_W-1:0]  old_idx_r;
  logic [31:0]        old_seen_r;
  logic [CNT_W-1:0]   removed_r;
  logic [15:0]        found_node_r;
  logic signed [15:0] found_rssi_r;
  logic signed [7:0]  found_snr_r;
  logic               found_direct_r;
  logic [31:0]        found_seen_r;

  // Result register
  out_item_t res_r;
  out_item_t res_nxt;
  logic      res_valid_r;
  logic      res_valid_nxt;

  // Scan read port and derived flags
  logic              rd_occ;
  logic [15:0]       rd_node;
  logic [31:0]       rd_seen;
  logic              last;
  logic              slot_match;
  logic              age_hit;
  logic              older;
  logic [SLOT_W-1:0] wr_idx;
  logic              evict;

  assign rd_occ  = occ_r[idx_r];
  assign rd_node = node_r[idx_r];
  assign rd_seen = seen_r[idx_r];
  assign last    = (idx_r == SLOT_W'(TABLE_SLOTS - 1));

  assign slot_match = rd_occ && (rd_node == cmd_r.node);
  assign age_hit    = rd_occ && ((cmd_r.now - rd_seen) >= cfg.max_age);
  assign older      = (idx_r == '0) || (rd_seen < old_seen_r);

  // Pick the slot an update writes
  assign wr_idx = hit_r ? hit_idx_r : (free_r ? free_idx_r : old_idx_r);
  assign evict  = ~hit_r & ~free_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty && !res_valid_r) begin
          state_nxt = (q_data.op == OP_CLEAR) ? ST_COMMIT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    start   = 1'b0;
    scan_en = 1'b0;
    commit  = 1'b0;
    unique case (state_r)
      ST_IDLE:   start   = ~q_empty & ~res_valid_r;
      ST_SCAN:   scan_en = 1'b1;
      ST_COMMIT: commit  = 1'b1;
      default: ;
    endcase
  end

  assign q_pop = start;

  // Occupancy and count updates
  always_comb begin
    occ_nxt     = occ_r;
    occ_cnt_nxt = occ_cnt_r;
    if (scan_en && (cmd_r.op == OP_AGE) && age_hit) begin
      occ_nxt[idx_r] = 1'b0;
      occ_cnt_nxt    = occ_cnt_r - 1'b1;
    end
    if (commit) begin
      case (cmd_r.op)
        OP_UPDATE: begin
          if (!hit_r) begin
            occ_nxt[wr_idx] = 1'b1;
            if (free_r) begin
              occ_cnt_nxt = occ_cnt_r + 1'b1;
            end
          end
        end
        OP_CLEAR: begin
          occ_nxt     = '0;
          occ_cnt_nxt = '0;
        end
        default: ;
      endcase
    end
  end

  // Build the result word
  always_comb begin
    res_nxt                = '0;
    res_nxt.status         = STATUS_OK;
    res_nxt.occupied_count = COUNT_OUT_W'(occ_cnt_nxt);
    case (cmd_r.op)
      OP_UPDATE: res_nxt.evicted = evict;
      OP_LOOKUP: begin
        if (hit_r) begin
          res_nxt.found_node_id   = found_node_r;
          res_nxt.found_rssi      = found_rssi_r;
          res_nxt.found_snr       = found_snr_r;
          res_nxt.found_direct    = found_direct_r;
          res_nxt.found_last_seen = found_seen_r;
        end else begin
          res_nxt.status = STATUS_MISS;
        end
      end
      OP_AGE:  res_nxt.removed_count = COUNT_OUT_W'(removed_r);
      default: ;
    endcase
  end

  assign res_valid_nxt = commit | (res_valid_r & ~pop);
  assign empty         = ~res_valid_r;
  assign out_data      = res_r;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      occ_r       <= '0;
      occ_cnt_r   <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      occ_cnt_r   <= occ_cnt_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  // Latch the command and track matches, free slot, oldest slot, removals
  always_ff @(posedge clk) begin
    if (start) begin
      cmd_r     <= q_data;
      idx_r     <= '0;
      hit_r     <= 1'b0;
      free_r    <= 1'b0;
      removed_r <= '0;
    end else if (scan_en) begin
      if (!last) begin
        idx_r <= idx_r + 1'b1;
      end
      if (slot_match && !hit_r) begin
        hit_r          <= 1'b1;
        hit_idx_r      <= idx_r;
        found_node_r   <= rd_node;
        found_rssi_r   <= rssi_r[idx_r];
        found_snr_r    <= snr_r[idx_r];
        found_direct_r <= direct_r[idx_r];
        found_seen_r   <= rd_seen;
      end
      if (!rd_occ && !free_r) begin
        free_r     <= 1'b1;
        free_idx_r <= idx_r;
      end
      if (older) begin
        old_idx_r  <= idx_r;
        old_seen_r <= rd_seen;
      end
      if ((cmd_r.op == OP_AGE) && age_hit) begin
        removed_r <= removed_r + 1'b1;
      end
    end
  end

  // Write the chosen slot on an update
  always_ff @(posedge clk) begin
    if (commit && (cmd_r.op == OP_UPDATE)) begin
      rssi_r[wr_idx] <= cmd_r.rssi;
      snr_r[wr_idx]  <= cmd_r.snr;
      seen_r[wr_idx] <= cmd_r.now;
      if (hit_r) begin
        if (cmd_r.heard_direct) begin
          direct_r[wr_idx] <= 1'b1;
        end
      end else begin
        node_r[wr_idx]   <= cmd_r.node;
        direct_r[wr_idx] <= cmd_r.heard_direct;
      end
    end
  end

  // Hold the result until popped
  always_ff @(posedge clk) begin
    if (commit) begin
      res_r <= res_nxt;
    end
  end

endmodule

[design/neighbor_table_oldest_evict.sv]
// Neighbor table with oldest-entry eviction and aging.
// An accepted word is staged in the front end and queued; the back end then
// scans the table one slot per cycle and commits, but a clear skips the scan.
// Words queue while it works; it starts the next once the result is popped.
// Reset empties the table at once and restores max age 60, direct ttl 3.
module neighbor_table_oldest_evict import ntoe_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  output logic                  full,
  input  in_item_t              in_data,
  input  logic                  pop,
  output logic                  empty,
  output out_item_t             out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t cfg;
  logic q_push;
  logic q_full;
  cmd_t q_wr_data;
  logic q_pop;
  logic q_empty;
  cmd_t q_rd_data;

  // Configuration registers
  ntoe_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Accept and classify
  ntoe_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .cfg     (cfg),
    .q_push  (q_push),
    .q_data  (q_wr_data),
    .q_full  (q_full)
  );

  // Decoupling queue
  ntoe_cmdq u_cmdq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr_data),
    .full    (q_full),
    .pop     (q_pop),
    .empty   (q_empty),
    .rd_data (q_rd_data)
  );

  // Table scan and commit
  ntoe_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .q_empty  (q_empty),
    .q_data   (q_rd_data),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

endmodule
